FILE: sv/slt_pkg.sv
// Shared types, widths and operation codes of the sorted list table.
package slt_pkg;

    localparam int DEPTH   = 16;
    localparam int KEY_W   = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OP_W    = 3;
    localparam int SLOT_W  = 5;
    localparam int PLACE_W = 6;
    localparam int VALUE_W = 32;
    localparam int FILL_W  = 5;

    localparam int IN_BITS  = OP_W + KEY_W + SLOT_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 1 + PLACE_W + VALUE_W + FILL_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd1;
    localparam logic [OP_W-1:0] OP_FIND      = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_AT = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_AT   = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd5;

    // Broadcast control for the row of cells
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] pos;
        logic [KEY_W-1:0] key;
    } slt_ctl_t;

endpackage

FILE: sv/sorted_list_table.sv
// Top level of the sorted list table: a row of compare-and-shift cells plus a sequencer.
// A transaction is captured, its compare results are registered in lt_reg/eq_reg, and its
// result is registered in the shift pass, which waits while the previous result is unaccepted.
// A new operation is accepted only in the idle state, after both the compare and the shift pass.
// Reset (rst_n low, asynchronous) empties the table and drops any pending result;
// the stored keys themselves are not cleared and are only read below the fill count.
module sorted_list_table
    import slt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // operation[2:0], key[34:3], slot[39:35]
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // ok[0], place[6:1], entry_value[38:7], fill_count[43:39], zero fill above
    output logic [OUT_W-1:0] m_tdata
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOOK  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // Captured transaction
    logic [OP_W-1:0]    op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [SLOT_W-1:0]  slot_reg;

    // Compare results of the whole row
    logic [DEPTH-1:0]   lt_reg;
    logic [DEPTH-1:0]   eq_reg;
    logic [DEPTH-1:0]   cell_lt;
    logic [DEPTH-1:0]   cell_eq;
    logic [KEY_W-1:0]   cell_key [DEPTH];

    // Result register
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [OUT_W-1:0]   m_data_reg;
    logic [OUT_W-1:0]   m_data_next;

    logic               in_go;
    logic               apply_go;
    slt_ctl_t           ctl;

    // Position decode
    logic [DEPTH-1:0]   boundary;
    logic [CNT_W-1:0]   pos;
    logic               found;
    logic [PLACE_W-1:0] pos_one;
    logic               slot_ok;
    logic [IDX_W-1:0]   slot_idx;
    logic               full;

    logic               res_ok;
    logic [PLACE_W-1:0] res_place;
    logic [VALUE_W-1:0] res_value;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_go    = s_tvalid && s_tready;
    // Hold the shift pass while the previous result is still waiting
    assign apply_go = (state_reg == ST_APPLY) && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Row of cells: each takes its key from the left on insert, from the right on delete
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [KEY_W-1:0] left_k;
            logic [KEY_W-1:0] right_k;
            if (gi == 0)
            begin : g_first
                assign left_k = ctl.key;
            end
            else
            begin : g_mid_l
                assign left_k = cell_key[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_k = cell_key[gi];
            end
            else
            begin : g_mid_r
                assign right_k = cell_key[gi+1];
            end

            slt_cell u_cell (
                .clk        (clk),
                .cell_index (IDX_W'(gi)),
                .fill       (count_reg),
                .ctl        (ctl),
                .left_key   (left_k),
                .right_key  (right_k),
                .key        (cell_key[gi]),
                .lt         (cell_lt[gi]),
                .eq         (cell_eq[gi])
            );
        end
    endgenerate

    // The less-than flags form a run of ones from cell 0; the first zero is the
    // insertion point, or DEPTH when every cell holds a smaller key.
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
                boundary[i] = !lt_reg[i];
            else
                boundary[i] = !lt_reg[i] && lt_reg[i-1];
            pos = pos | (boundary[i] ? CNT_W'(i) : '0);
        end
        if (boundary == '0)
            pos = CNT_W'(DEPTH);
        found = |(boundary & eq_reg);
    end

    assign pos_one  = PLACE_W'(pos) + PLACE_W'(1);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign slot_ok  = (slot_reg != '0) && (CNT_W'(slot_reg) <= count_reg);
    assign slot_idx = IDX_W'(slot_reg - SLOT_W'(1));

    always_comb
    begin
        ctl        = '0;
        ctl.key    = key_reg;
        count_next = count_reg;
        res_ok     = 1'b0;
        res_place  = '0;
        res_value  = '0;
        unique case (op_reg)
            OP_INSERT:
            begin
                if (!full)
                begin
                    ctl.ins    = apply_go;
                    ctl.pos    = IDX_W'(pos);
                    count_next = count_reg + CNT_W'(1);
                    res_ok     = 1'b1;
                    res_place  = pos_one;
                end
            end
            OP_REMOVE:
            begin
                res_place = found ? pos_one : -pos_one;
                if (found)
                begin
                    ctl.del    = apply_go;
                    ctl.pos    = IDX_W'(pos);
                    count_next = count_reg - CNT_W'(1);
                    res_ok     = 1'b1;
                end
            end
            OP_FIND:
            begin
                res_place = found ? pos_one : -pos_one;
                res_ok    = found;
            end
            OP_REMOVE_AT:
            begin
                if (slot_ok)
                begin
                    ctl.del    = apply_go;
                    ctl.pos    = slot_idx;
                    count_next = count_reg - CNT_W'(1);
                    res_ok     = 1'b1;
                end
            end
            OP_READ_AT:
            begin
                if (slot_ok)
                begin
                    res_value = VALUE_W'(cell_key[slot_idx]);
                    res_ok    = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
                res_ok     = 1'b1;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        m_data_next = {{(OUT_W - OUT_BITS){1'b0}},
                       FILL_W'(count_next), res_value, res_place, res_ok};
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;
        if (apply_go)
            m_valid_next = 1'b1;
    end

    // Sequencer: capture, compare pass, shift pass
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_go)
                    state_next = ST_LOOK;
            ST_LOOK:
                state_next = ST_APPLY;
            ST_APPLY:
                if (apply_go)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (apply_go)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_go)
        begin
            op_reg   <= s_tdata[OP_W-1:0];
            key_reg  <= s_tdata[OP_W+KEY_W-1:OP_W];
            slot_reg <= s_tdata[OP_W+KEY_W+SLOT_W-1:OP_W+KEY_W];
        end
        if (state_reg == ST_LOOK)
        begin
            lt_reg <= cell_lt;
            eq_reg <= cell_eq;
        end
        if (apply_go)
            m_data_reg <= m_data_next;
    end

    // The table never holds more than DEPTH keys
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // Keys stay sorted, so the less-than flags are a run of ones from cell 0
    a_lt_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY) |-> (((lt_reg >> 1) & ~lt_reg) == '0))
        else $error("row of keys out of order");

    // A successful insert grows the table by one
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (apply_go && (op_reg == OP_INSERT) && !full)
            |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the table");

    // An accepted transaction always goes to the compare pass next
    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        in_go |=> (state_reg == ST_LOOK))
        else $error("accepted transaction not compared");

endmodule

FILE: sv/slt_cell.sv
// One cell of the sorted row: holds a key, compares it and shifts with its neighbors.
module slt_cell
    import slt_pkg::*;
(
    input  logic             clk,
    input  logic [IDX_W-1:0] cell_index,
    input  logic [CNT_W-1:0] fill,
    input  slt_ctl_t         ctl,
    input  logic [KEY_W-1:0] left_key,
    input  logic [KEY_W-1:0] right_key,
    output logic [KEY_W-1:0] key,
    output logic             lt,
    output logic             eq
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             occupied;

    assign occupied = {1'b0, cell_index} < fill;
    assign lt       = occupied && (ctl.key > key_reg);
    assign eq       = occupied && (ctl.key == key_reg);
    assign key      = key_reg;

    // Insert: open a gap by taking the left neighbor; delete: close it from the right
    always_comb
    begin
        key_next = key_reg;
        if (ctl.ins)
        begin
            if (cell_index > ctl.pos)
                key_next = left_key;
            else if (cell_index == ctl.pos)
                key_next = ctl.key;
        end
        else if (ctl.del && (cell_index >= ctl.pos))
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule
